// File: sv/mkld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkld_pkg
// Shared constants, types and the A to Z letter table of the morse key
// letter decoder.
// ----------------------------------------------------------------------------
package mkld_pkg;

  // sizing
  localparam int MAX_SYMBOLS = 5;
  localparam int TIMER_BITS  = 16;
  localparam int CFG_W       = 16;
  localparam int SYM_W       = MAX_SYMBOLS;
  localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int CMP_W       = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int NUM_LETTERS = 26;

  // output field widths
  localparam int CODE_W    = 5;
  localparam int PATTERN_W = 5;
  localparam int TOTAL_W   = 3;

  localparam logic [CODE_W-1:0] UNKNOWN_CODE = CODE_W'(26);

  // register map
  localparam int ADDR_W = 4;
  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_DOT_MAX  = 2'd1,
    REG_SILENCE  = 2'd2
  } reg_idx_e;

  // reset values of the registers
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(50);
  localparam logic [CFG_W-1:0] DOT_MAX_RST  = CFG_W'(400);
  localparam logic [CFG_W-1:0] SILENCE_RST  = CFG_W'(1200);

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] dot_max_ticks;
    logic [CFG_W-1:0] silence_ticks;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0]    letter_code;
    logic [PATTERN_W-1:0] symbol_pattern;
    logic [TOTAL_W-1:0]   symbol_total;
  } result_t;

  // letter table: bit i is symbol i, 1 dash 0 dot
  localparam logic [3:0] LETTER_BITS [NUM_LETTERS] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14,
    4'd5, 4'd2, 4'd3, 4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1,
    4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };
  localparam logic [2:0] LETTER_LEN [NUM_LETTERS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
    3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  // parallel match against every table entry
  function automatic logic [CODE_W-1:0] lookup_letter(
    input logic [SYM_W-1:0] bits,
    input logic [CNT_W-1:0] cnt
  );
    logic [CODE_W-1:0] code;
    code = UNKNOWN_CODE;
    for (int k = NUM_LETTERS - 1; k >= 0; k--) begin
      if (bits == SYM_W'(LETTER_BITS[k]) && cnt == CNT_W'(LETTER_LEN[k])) begin
        code = CODE_W'(k);
      end
    end
    return code;
  endfunction

endpackage

// File: sv/mkld_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkld_cfg_regs
// APB-style register block holding the debounce, dot and silence limits.
// ----------------------------------------------------------------------------
module mkld_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mkld_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output mkld_pkg::cfg_t             cfg_o
);
  import mkld_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  // word index from the byte address
  assign idx   = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= DEBOUNCE_RST;
      cfg_q.dot_max_ticks  <= DOT_MAX_RST;
      cfg_q.silence_ticks  <= SILENCE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE: cfg_q.debounce_ticks <= pwdata[CFG_W-1:0];
        REG_DOT_MAX:  cfg_q.dot_max_ticks  <= pwdata[CFG_W-1:0];
        REG_SILENCE:  cfg_q.silence_ticks  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_DEBOUNCE: prdata = 32'(cfg_q.debounce_ticks);
      REG_DOT_MAX:  prdata = 32'(cfg_q.dot_max_ticks);
      REG_SILENCE:  prdata = 32'(cfg_q.silence_ticks);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/mkld_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkld_decoder
// Per-tick key state: edge handling, press and silence timers, symbol
// buffer and the letter lookup when a letter ends.
// ----------------------------------------------------------------------------
module mkld_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              key_level_i,
  input  mkld_pkg::cfg_t    cfg_i,
  output logic              emit_o,
  output mkld_pkg::result_t result_o
);
  import mkld_pkg::*;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam int SYM_EXT_W = (SYM_W > PATTERN_W) ? SYM_W : PATTERN_W;
  localparam int CNT_EXT_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

  logic                  prev_q, prev_d;
  logic [TIMER_BITS-1:0] press_q, press_d, press_adv;
  logic [TIMER_BITS-1:0] sil_q, sil_d, sil_adv;
  logic [SYM_W-1:0]      held_q, held_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [SYM_EXT_W-1:0]  held_ext;
  logic [CNT_EXT_W-1:0]  cnt_ext;

  // saturating timer advance
  assign press_adv = (press_q == TIMER_MAX) ? press_q : press_q + 1'b1;
  assign sil_adv   = (sil_q == TIMER_MAX) ? sil_q : sil_q + 1'b1;

  // edge handling and end of letter
  always_comb begin
    prev_d  = key_level_i;
    press_d = press_adv;
    sil_d   = sil_adv;
    held_d  = held_q;
    cnt_d   = cnt_q;
    emit_o  = 1'b0;
    priority if (prev_q && !key_level_i) begin
      press_d = '0;
    end else if (!prev_q && key_level_i) begin
      if (CMP_W'(press_adv) > CMP_W'(cfg_i.debounce_ticks)) begin
        sil_d = '0;
        if (cnt_q < CNT_W'(MAX_SYMBOLS)) begin
          if (CMP_W'(press_adv) >= CMP_W'(cfg_i.dot_max_ticks)) begin
            held_d = held_q | (SYM_W'(1) << cnt_q);
          end
          cnt_d = cnt_q + 1'b1;
        end
      end
    end else if (key_level_i && cnt_q != '0 &&
                 CMP_W'(sil_adv) > CMP_W'(cfg_i.silence_ticks)) begin
      emit_o = 1'b1;
      held_d = '0;
      cnt_d  = '0;
    end
  end

  // result fields from the held symbols
  assign held_ext = SYM_EXT_W'(held_q);
  assign cnt_ext  = CNT_EXT_W'(cnt_q);
  assign result_o.letter_code    = lookup_letter(held_q, cnt_q);
  assign result_o.symbol_pattern = held_ext[PATTERN_W-1:0];
  assign result_o.symbol_total   = cnt_ext[TOTAL_W-1:0];

  // state update, one tick per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b1;
      press_q <= '0;
      sil_q   <= '0;
      held_q  <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      prev_q  <= prev_d;
      press_q <= press_d;
      sil_q   <= sil_d;
      held_q  <= held_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: sv/morse_key_letter_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_letter_decoder_core
// Decodes ticks of a sampled morse key into A to Z letter words.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  tick    | in_valid_i / in_ready_o, key_level_i      | in
//  letter  | out_valid_o / out_ready_i, letter_code_o, | out
//          | symbol_pattern_o, symbol_total_o          |
//  config  | psel, penable, pwrite, paddr, pwdata,     | in / out
//          | prdata, pready                            |
//
// One tick word per cycle while the update stage is not stalled: an input
// register, the state update and lookup, then a result register. A held
// letter stalls the update stage only when the next tick would produce
// another letter; other ticks keep flowing.
// Reset sets the limits to 50, 400 and 1200, clears the timers and symbols and sets the previous key level high.
// ----------------------------------------------------------------------------
module morse_key_letter_decoder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        key_level_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mkld_pkg::CODE_W-1:0]    letter_code_o,
  output logic [mkld_pkg::PATTERN_W-1:0] symbol_pattern_o,
  output logic [mkld_pkg::TOTAL_W-1:0]   symbol_total_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mkld_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import mkld_pkg::*;

  cfg_t    cfg;
  result_t dec_res;
  result_t res_q;
  logic    dec_emit;
  logic    tick_vld_q, tick_lvl_q;
  logic    res_vld_q;
  logic    step;

  mkld_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // update stage advances unless a new letter would meet a full result register that is not being read
  assign step       = tick_vld_q && (!dec_emit || !res_vld_q || out_ready_i);
  assign in_ready_o = !tick_vld_q || step;

  mkld_decoder u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .key_level_i (tick_lvl_q),
    .cfg_i       (cfg),
    .emit_o      (dec_emit),
    .result_o    (dec_res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      tick_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tick_lvl_q <= key_level_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (step && dec_emit) begin
      res_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && dec_emit) begin
      res_q <= dec_res;
    end
  end

  assign out_valid_o      = res_vld_q;
  assign letter_code_o    = res_q.letter_code;
  assign symbol_pattern_o = res_q.symbol_pattern;
  assign symbol_total_o   = res_q.symbol_total;

endmodule
